// File: rtl/stcf_pkg.sv
// stcf_pkg: types, codes and helpers shared by the stage command framer
// used by every module of stage_command_framer_unit and by its checker
package stcf_pkg;

   localparam int FRAME_LEN     = 8;
   localparam int NUM_AXES      = 3;
   localparam int QUEUE_DEPTH   = 2;

   // operation codes on the request side
   localparam logic [2:0] OP_MOVE   = 3'd0;
   localparam logic [2:0] OP_RESET  = 3'd1;
   localparam logic [2:0] OP_LIGHT  = 3'd2;
   localparam logic [2:0] OP_REPLY  = 3'd3;
   localparam logic [2:0] OP_PRESET = 3'd4;

   // frame bytes
   localparam logic [7:0] SYNC_BYTE     = 8'h55;
   localparam logic [7:0] OPCODE_MOVE   = 8'h01;
   localparam logic [7:0] OPCODE_RESET  = 8'h03;
   localparam logic [7:0] OPCODE_LIGHT  = 8'h08;
   localparam logic [7:0] REPLY_OK      = 8'd170;

   // axis codes
   localparam logic [7:0] AXIS_Z = 8'h01;
   localparam logic [7:0] AXIS_X = 8'h02;
   localparam logic [7:0] AXIS_Y = 8'h03;

   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_REPLY = 1'b1;

   typedef struct packed {
      logic [2:0]         operation;
      logic [7:0]         axis;
      logic signed [31:0] step_amount;
      logic [7:0]         light_level;
      logic [7:0]         rx_byte;
      logic signed [31:0] preset_value;
   } req_type;

   typedef struct packed {
      logic               result_kind;
      logic [7:0]         tx_byte;
      logic               last;
      logic               reply_status;
      logic signed [31:0] axis_position;
   } rsp_type;

   // one unit of work handed from front to back
   typedef struct packed {
      logic               is_reply;
      logic [7:0]         opcode;
      logic [7:0]         axis;
      logic [31:0]        data;
      logic signed [31:0] position;
      logic               status;
   } job_type;

   typedef struct packed {
      logic       known;
      logic [1:0] index;
   } axis_sel_type;

   function automatic axis_sel_type decode_axis(input logic [7:0] code);
      axis_sel_type sel;
      sel.known = 1'b1;
      sel.index = 2'd0;
      unique case (code)
         AXIS_Z:  sel.index = 2'd0;
         AXIS_X:  sel.index = 2'd1;
         AXIS_Y:  sel.index = 2'd2;
         default: sel.known = 1'b0;
      endcase
      return sel;
   endfunction

   // sum of byte i shifted left by i, modulo 256, over bytes 0..6
   function automatic logic [7:0] frame_checksum(input job_type job);
      logic [7:0] sum;
      sum = job.opcode
          + 8'(SYNC_BYTE << 1)
          + 8'(job.axis << 2)
          + 8'(job.data[31:24] << 3)
          + 8'(job.data[23:16] << 4)
          + 8'(job.data[15:8] << 5)
          + 8'(job.data[7:0] << 6);
      return sum;
   endfunction

endpackage

// File: rtl/stcf_queue.sv
// stcf_queue: small job queue between the framer front and back
// depends on stcf_pkg for job_type
module stcf_queue
   import stcf_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  job_type wr_data,
   output logic    q_full,
   input  logic    rd_en,
   output job_type rd_data,
   output logic    q_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_wr, do_rd;

   assign q_full  = (count_ff == CNT_W'(DEPTH));
   assign q_empty = (count_ff == '0);
   assign rd_data = slot_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: rtl/stcf_front.sv
// stcf_front: accepts requests, keeps axis positions and the reply buffer,
// and turns each command into a job; depends on stcf_pkg
module stcf_front
   import stcf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_accept,
   input  req_type req_data,
   output logic    job_valid,
   output job_type job_data
);

   logic signed [31:0] pos_ff [NUM_AXES];
   logic [7:0]         reply_buf_ff [FRAME_LEN];
   logic [2:0]         reply_count_ff, reply_count_in;

   axis_sel_type       sel;
   logic [7:0]         sel_code;
   logic signed [31:0] cur_pos, sum_pos, reply_pos, new_pos;
   logic               pos_we, reply_ok;

   assign sel_code  = (req_data.operation == OP_REPLY) ? reply_buf_ff[2] : req_data.axis;
   assign sel       = decode_axis(sel_code);
   assign cur_pos   = pos_ff[sel.index];
   assign sum_pos   = cur_pos + req_data.step_amount;
   assign reply_ok  = (reply_buf_ff[1] == REPLY_OK);
   assign reply_pos = {reply_buf_ff[3], reply_buf_ff[4], reply_buf_ff[5], reply_buf_ff[6]};

   always_comb begin
      job_valid      = 1'b0;
      job_data       = '0;
      pos_we         = 1'b0;
      new_pos        = '0;
      reply_count_in = reply_count_ff;
      unique case (req_data.operation)
         OP_MOVE: begin
            job_valid       = 1'b1;
            job_data.opcode = OPCODE_MOVE;
            job_data.axis   = req_data.axis;
            if (sel.known) begin
               pos_we            = 1'b1;
               new_pos           = sum_pos;
               job_data.data     = sum_pos;
               job_data.position = sum_pos;
            end
         end
         OP_RESET: begin
            job_valid       = 1'b1;
            job_data.opcode = OPCODE_RESET;
            job_data.axis   = req_data.axis;
            pos_we          = sel.known;
         end
         OP_LIGHT: begin
            job_valid       = 1'b1;
            job_data.opcode = OPCODE_LIGHT;
            job_data.data   = {req_data.light_level, 24'h0};
         end
         OP_REPLY: begin
            reply_count_in = reply_count_ff + 1'b1;
            if (reply_count_ff == 3'(FRAME_LEN - 1)) begin
               job_valid         = 1'b1;
               job_data.is_reply = 1'b1;
               job_data.status   = !reply_ok;
               if (sel.known) begin
                  pos_we            = reply_ok;
                  new_pos           = reply_pos;
                  job_data.position = reply_ok ? reply_pos : cur_pos;
               end
            end
         end
         OP_PRESET: begin
            pos_we  = sel.known;
            new_pos = req_data.preset_value;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reply_count_ff <= '0;
         for (int i = 0; i < NUM_AXES; i++) begin
            pos_ff[i] <= '0;
         end
      end else if (req_accept) begin
         reply_count_ff <= reply_count_in;
         if (pos_we) begin
            pos_ff[sel.index] <= new_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_data.operation == OP_REPLY) begin
         reply_buf_ff[reply_count_ff] <= req_data.rx_byte;
      end
   end

endmodule

// File: rtl/stcf_back.sv
// stcf_back: serializes jobs into frame bytes or a reply result
// behind a registered result stage; depends on stcf_pkg
module stcf_back
   import stcf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    job_present,
   input  job_type job_data,
   output logic    job_done,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic [2:0]  idx_ff, idx_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;
   logic        advance, final_item;
   logic [7:0]  frame_byte;

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;
   assign advance  = job_present && (!out_valid_ff || pop);
   assign final_item = job_data.is_reply || (idx_ff == 3'(FRAME_LEN - 1));
   assign job_done = advance && final_item;

   always_comb begin
      unique case (idx_ff)
         3'd0:    frame_byte = job_data.opcode;
         3'd1:    frame_byte = SYNC_BYTE;
         3'd2:    frame_byte = job_data.axis;
         3'd3:    frame_byte = job_data.data[31:24];
         3'd4:    frame_byte = job_data.data[23:16];
         3'd5:    frame_byte = job_data.data[15:8];
         3'd6:    frame_byte = job_data.data[7:0];
         default: frame_byte = frame_checksum(job_data);
      endcase
   end

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      idx_in       = idx_ff;
      if (advance) begin
         out_valid_in         = 1'b1;
         out_in.result_kind   = job_data.is_reply ? KIND_REPLY : KIND_FRAME;
         out_in.tx_byte       = job_data.is_reply ? 8'h00 : frame_byte;
         out_in.last          = final_item;
         out_in.reply_status  = job_data.is_reply & job_data.status;
         out_in.axis_position = job_data.position;
         idx_in               = final_item ? 3'd0 : idx_ff + 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

// File: rtl/stage_command_framer_unit.sv
// Stage command framer. Commands (move, reset axis, set light) each produce
// an eight-byte frame, one byte per transfer on the result side; every eighth
// reply byte produces one reply check result, other reply bytes and presets
// produce none. Position updates take effect at the request transfer, so a
// following command sees them at once. Frame output runs at one byte per
// cycle while results are popped without stall; the job queue lets the next
// requests enter meanwhile and full rises only when it holds QUEUE_DEPTH_P
// jobs not yet fully sent. Reply bytes and presets are accepted whenever
// full is low. With both sides idle, the first result passes the job queue
// and then the registered result stage after the request transfer.
module stage_command_framer_unit
   import stcf_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic    req_accept;
   logic    job_valid, job_done, q_empty;
   job_type job_in, job_head;

   assign req_accept = push && !full;

   stcf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .job_valid  (job_valid),
      .job_data   (job_in)
   );

   stcf_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_accept && job_valid),
      .wr_data (job_in),
      .q_full  (full),
      .rd_en   (job_done),
      .rd_data (job_head),
      .q_empty (q_empty)
   );

   stcf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_present (!q_empty),
      .job_data    (job_head),
      .job_done    (job_done),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data)
   );

endmodule

// File: rtl/stcf_checker.sv
// stcf_checker: port-level assertions for stage_command_framer_unit
// depends on stcf_pkg; bound to the top level below
module stcf_checker
   import stcf_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    push,
   input logic    full,
   input req_type req_data,
   input logic    empty,
   input logic    pop,
   input rsp_type rsp_data
);

   // nothing to show right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result present after reset");

   // a waiting result holds until its transfer
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("result changed while stalled");

   // reply results carry no frame byte and always close
   a_reply_shape: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.result_kind == KIND_REPLY)
         |-> (rsp_data.last && rsp_data.tx_byte == 8'h00))
      else $error("malformed reply result");

   // frame bytes never report a reply failure
   a_frame_status: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.result_kind == KIND_FRAME) |-> !rsp_data.reply_status)
      else $error("frame byte with reply status");

   // the byte after a closing frame byte starts a new frame with an opcode
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && rsp_data.result_kind == KIND_FRAME && rsp_data.last)
         ##1 (!empty && rsp_data.result_kind == KIND_FRAME)
         |-> (rsp_data.tx_byte == OPCODE_MOVE || rsp_data.tx_byte == OPCODE_RESET
              || rsp_data.tx_byte == OPCODE_LIGHT))
      else $error("frame does not start with an opcode");

endmodule

bind stage_command_framer_unit stcf_checker u_checker (.*);

// File: tb/stage_command_framer_unit_test.sv
// Self-checking test of stage_command_framer_unit: a directed table, then random commands,
// preset writes and reply frames, with random idle bursts on both queue sides.
// Depends on stcf_pkg and the RTL; results match a position/frame predictor or a typed table row.
module stage_command_framer_unit_test;
   import stcf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] OP_UNUSED_LAST = 3'd7;
   localparam int         WATCHDOG_LIMIT = 1000;
   localparam int         TARGET_ITEMS   = 310;
   localparam int         CALM_ITEMS     = 270;

   typedef struct packed {
      req_type     item;
      logic        typed;
      logic [63:0] frame;
      logic [31:0] position;
   } directed_row;

   logic    clock;
   logic    reset    = 1'b1;
   logic    push     = 1'b0;
   logic    pop      = 1'b0;
   req_type req_data = '0;
   logic    full;
   logic    empty;
   rsp_type rsp_data;

   logic [31:0] stage_pos [3];
   logic [7:0]  reply_bytes [8];
   logic [2:0]  reply_fill;
   rsp_type     fresh_results [$];
   rsp_type     pending_results [$];
   directed_row plan [$];

   int item_count     = 0;
   int mismatch_count = 0;
   int quiet_cycles   = 0;
   int stall_left     = 0;
   bit calm           = 1'b0;

   stage_command_framer_unit dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int axis_slot(input logic [7:0] code);
      case (code)
         AXIS_Z:  return 0;
         AXIS_X:  return 1;
         AXIS_Y:  return 2;
         default: return -1;
      endcase
   endfunction

   function automatic void queue_frame(input logic [7:0] opcode, input logic [7:0] code,
                                       input logic [31:0] data, input logic [31:0] pos);
      logic [7:0] fb [8];
      logic [7:0] sum;
      rsp_type    r;
      fb[0] = opcode;
      fb[1] = SYNC_BYTE;
      fb[2] = code;
      fb[3] = data[31:24];
      fb[4] = data[23:16];
      fb[5] = data[15:8];
      fb[6] = data[7:0];
      sum = '0;
      for (int i = 0; i < 7; i++) sum = sum + 8'(fb[i] << i);
      fb[7] = sum;
      for (int i = 0; i < 8; i++) begin
         r.result_kind   = KIND_FRAME;
         r.tx_byte       = fb[i];
         r.last          = (i == 7);
         r.reply_status  = 1'b0;
         r.axis_position = pos;
         fresh_results.push_back(r);
      end
   endfunction

   function automatic void predict_stage_output(input req_type item);
      int          slot;
      logic        ok;
      logic [31:0] pos;
      rsp_type     r;
      slot = axis_slot(item.axis);
      pos = '0;
      case (item.operation)
         OP_MOVE: begin
            if (slot >= 0) begin
               stage_pos[slot] = stage_pos[slot] + item.step_amount;
               pos = stage_pos[slot];
            end
            queue_frame(OPCODE_MOVE, item.axis, pos, pos);
         end
         OP_RESET: begin
            if (slot >= 0) stage_pos[slot] = '0;
            queue_frame(OPCODE_RESET, item.axis, '0, '0);
         end
         OP_LIGHT: begin
            queue_frame(OPCODE_LIGHT, 8'h00, {item.light_level, 24'h0}, '0);
         end
         OP_REPLY: begin
            reply_bytes[reply_fill] = item.rx_byte;
            reply_fill = reply_fill + 3'd1;
            if (reply_fill == 3'd0) begin
               ok = (reply_bytes[1] == REPLY_OK);
               slot = axis_slot(reply_bytes[2]);
               if (slot >= 0) begin
                  if (ok) stage_pos[slot] = {reply_bytes[3], reply_bytes[4],
                                             reply_bytes[5], reply_bytes[6]};
                  pos = stage_pos[slot];
               end
               r.result_kind   = KIND_REPLY;
               r.tx_byte       = 8'h00;
               r.last          = 1'b1;
               r.reply_status  = ~ok;
               r.axis_position = pos;
               fresh_results.push_back(r);
            end
         end
         OP_PRESET: begin
            if (slot >= 0) stage_pos[slot] = item.preset_value;
         end
         default: ;
      endcase
   endfunction

   // typed rows replace the predicted frame with the one written in the table
   function automatic void book_expected(input req_type item, input logic typed,
                                         input logic [63:0] frame, input logic [31:0] pos);
      rsp_type r;
      predict_stage_output(item);
      if (typed) begin
         fresh_results.delete();
         for (int i = 0; i < 8; i++) begin
            r.result_kind   = KIND_FRAME;
            r.tx_byte       = frame[63 - 8*i -: 8];
            r.last          = (i == 7);
            r.reply_status  = 1'b0;
            r.axis_position = pos;
            pending_results.push_back(r);
         end
      end else begin
         while (fresh_results.size() != 0) pending_results.push_back(fresh_results.pop_front());
      end
   endfunction

   function automatic req_type command_req(input logic [2:0] op, input logic [7:0] code,
                                           input logic [31:0] value);
      req_type r;
      r.operation    = op;
      r.axis         = code;
      r.step_amount  = value;
      r.light_level  = value[7:0];
      r.rx_byte      = value[7:0];
      r.preset_value = value;
      return r;
   endfunction

   function automatic req_type random_req();
      req_type r;
      r.operation    = 3'($urandom);
      r.axis         = 8'($urandom);
      r.step_amount  = $urandom;
      r.light_level  = 8'($urandom);
      r.rx_byte      = 8'($urandom);
      r.preset_value = $urandom;
      return r;
   endfunction

   function automatic logic [7:0] random_axis();
      if ($urandom_range(0, 4) != 0) return 8'($urandom_range(AXIS_Z, AXIS_Y));
      return 8'($urandom);
   endfunction

   function automatic void add_frame(input req_type item, input logic [63:0] frame,
                                     input logic [31:0] pos);
      plan.push_back('{item, 1'b1, frame, pos});
   endfunction

   function automatic void add_step(input req_type item);
      plan.push_back('{item, 1'b0, 64'h0, 32'h0});
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_item(input req_type item, input logic typed,
                            input logic [63:0] frame, input logic [31:0] pos);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 11);
         push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      push = 1'b1;
      req_data = item;
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
      book_expected(item, typed, frame, pos);
      if (item.operation <= OP_PRESET) item_count++;
      calm = (item_count >= CALM_ITEMS);
   endtask

   task automatic send_random(input req_type item);
      send_item(item, 1'b0, '0, '0);
   endtask

   task automatic drain_results();
      push = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic send_stray_reply();
      req_type item;
      item = random_req();
      item.operation = OP_REPLY;
      send_random(item);
   endtask

   task automatic send_reply_frame();
      logic [7:0] rb [8];
      req_type    item;
      while (reply_fill != 3'd0) send_stray_reply();
      for (int i = 0; i < 8; i++) rb[i] = 8'($urandom);
      if ($urandom_range(0, 4) != 0) rb[1] = REPLY_OK;
      rb[2] = random_axis();
      for (int i = 0; i < 8; i++) begin
         item = random_req();
         item.operation = OP_REPLY;
         item.rx_byte = rb[i];
         send_random(item);
      end
   endtask

   task automatic send_random_command();
      req_type item;
      item = random_req();
      item.operation = 3'($urandom_range(OP_MOVE, OP_LIGHT));
      item.axis = random_axis();
      if ($urandom_range(0, 1) == 0) item.step_amount = int'($urandom_range(0, 64)) - 32;
      send_random(item);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         pop = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         pop = 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
         stall_left = $urandom_range(1, 11) - 1;
         pop = 1'b0;
      end else begin
         pop = 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && pop && !empty) begin
         if (pending_results.size() == 0) begin
            $error("unexpected transfer tx_byte %h kind %0d", rsp_data.tx_byte,
                   rsp_data.result_kind);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.result_kind !== want.result_kind) begin
               $error("result_kind expected %0d got %0d", want.result_kind,
                      rsp_data.result_kind);
               mismatch_count++;
            end
            if (rsp_data.tx_byte !== want.tx_byte) begin
               $error("tx_byte expected %h got %h", want.tx_byte, rsp_data.tx_byte);
               mismatch_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last expected %0d got %0d", want.last, rsp_data.last);
               mismatch_count++;
            end
            if (rsp_data.reply_status !== want.reply_status) begin
               $error("reply_status expected %0d got %0d", want.reply_status,
                      rsp_data.reply_status);
               mismatch_count++;
            end
            if (rsp_data.axis_position !== want.axis_position) begin
               $error("axis_position expected %0d got %0d", want.axis_position,
                      rsp_data.axis_position);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int  pick;
      bit  mid_drained;
      req_type item;
      for (int i = 0; i < 3; i++) stage_pos[i] = '0;
      reply_fill = '0;
      mid_drained = 1'b0;

      add_frame(command_req(OP_MOVE, AXIS_Z, 32'd1), 64'h0155_0100_0000_01EF, 32'd1);
      add_frame(command_req(OP_MOVE, AXIS_X, 32'h7FFF_FFFF), 64'h0155_027F_FFFF_FF3B,
                32'h7FFF_FFFF);
      add_frame(command_req(OP_MOVE, AXIS_X, 32'd1), 64'h0155_0280_0000_00B3, 32'h8000_0000);
      add_step(command_req(OP_MOVE, AXIS_X, 32'h8000_0000));
      add_step(command_req(OP_MOVE, AXIS_Y, 32'hFFFF_FFFF));
      add_frame(command_req(OP_MOVE, 8'h00, 32'hFFFF_FFFF), 64'h0155_0000_0000_00AB, 32'd0);
      add_step(command_req(OP_MOVE, 8'hFF, 32'd5));
      add_step(command_req(OP_RESET, AXIS_Y, 32'd0));
      add_frame(command_req(OP_RESET, 8'hFF, 32'd0), 64'h0355_FF00_0000_00A9, 32'd0);
      add_frame(command_req(OP_LIGHT, 8'hFF, 32'hFF), 64'h0855_00FF_0000_00AA, 32'd0);
      add_step(command_req(OP_LIGHT, AXIS_X, 32'd0));
      add_step(command_req(OP_PRESET, AXIS_Z, 32'h8000_0000));
      add_step(command_req(OP_PRESET, AXIS_X, 32'h7FFF_FFFF));
      add_step(command_req(OP_PRESET, 8'h04, 32'h1234_5678));
      add_step(command_req(OP_MOVE, AXIS_Z, 32'd0));
      add_step(command_req(OP_UNUSED_LAST, AXIS_X, 32'hFFFF_FFFF));
      add_step(command_req(OP_REPLY, 8'h00, 32'h00));
      add_step(command_req(OP_REPLY, 8'h00, 32'hAA));
      add_step(command_req(OP_REPLY, 8'h00, 32'h03));
      add_step(command_req(OP_REPLY, 8'h00, 32'h12));
      add_step(command_req(OP_REPLY, 8'h00, 32'h34));
      add_step(command_req(OP_REPLY, 8'h00, 32'h56));
      add_step(command_req(OP_REPLY, 8'h00, 32'h78));
      add_step(command_req(OP_REPLY, 8'h00, 32'hFF));
      add_step(command_req(OP_MOVE, AXIS_Y, 32'd1));

      repeat (2) @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) send_item(plan[i].item, plan[i].typed, plan[i].frame, plan[i].position);

      drain_results();
      while (item_count < TARGET_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            send_random_command();
         end else if (pick < 70) begin
            send_reply_frame();
         end else if (pick < 80) begin
            item = random_req();
            item.operation = OP_PRESET;
            item.axis = random_axis();
            send_random(item);
         end else if (pick < 88) begin
            send_stray_reply();
         end else if (pick < 94) begin
            item = random_req();
            item.operation = 3'($urandom_range(OP_MOVE, OP_PRESET));
            send_random(item);
         end else begin
            item = random_req();
            item.operation = 3'($urandom_range(OP_PRESET + 1, OP_UNUSED_LAST));
            send_random(item);
         end
         if (!mid_drained && item_count >= TARGET_ITEMS / 2) begin
            mid_drained = 1'b1;
            drain_results();
         end
      end

      drain_results();
      repeat (16) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/stcf_pkg.sv
rtl/stcf_queue.sv
rtl/stcf_front.sv
rtl/stcf_back.sv
rtl/stage_command_framer_unit.sv
rtl/stcf_checker.sv
tb/stage_command_framer_unit_test.sv
